// File: rtl/jse_pkg.sv
// ----------------------------------------------------------------------------
// jse_pkg
// Shared types and constants of the JSON string escaper.
// ----------------------------------------------------------------------------
package jse_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int CP_W        = 21;

    // work codes
    localparam logic [1:0] OP_NONE = 2'd0;
    localparam logic [1:0] OP_RAW  = 2'd1;
    localparam logic [1:0] OP_ESC2 = 2'd2;
    localparam logic [1:0] OP_CODE = 2'd3;

    // characters
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;

    localparam logic [CP_W-1:0] CP_BMP_MAX = 21'h00FFFF;
    localparam logic [CP_W-1:0] CP_PLANE1  = 21'h010000;
    localparam logic [5:0]      SURR_HI    = 6'b110110;
    localparam logic [5:0]      SURR_LO    = 6'b110111;

    typedef struct packed {
        logic            open_q;
        logic [1:0]      op;
        logic [7:0]      ch;
        logic [CP_W-1:0] code;
        logic            close_q;
    } t_job;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] r;
        if (nib < 4'd10) begin
            r = 8'h30 + {4'd0, nib};
        end else begin
            r = 8'h37 + {4'd0, nib};
        end
        return r;
    endfunction

endpackage

// File: rtl/jse_front.sv
// ----------------------------------------------------------------------------
// jse_front
// Classifies input bytes, gathers UTF-8 sequences and issues at most one job per item.
// ----------------------------------------------------------------------------
module jse_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic           i_kind,
    input  logic [7:0]     i_data_byte,
    output logic           o_push,
    output jse_pkg::t_job  o_job
);

    logic                      r_at_start, n_at_start;
    logic [1:0]                r_pend, n_pend;
    logic [jse_pkg::CP_W-1:0]  r_accum, n_accum;
    logic [jse_pkg::CP_W-1:0]  acc_next;
    logic [1:0]                pend_dec;
    jse_pkg::t_job             job;

    assign acc_next = {r_accum[jse_pkg::CP_W-7:0], i_data_byte[5:0]};
    assign pend_dec = r_pend - 2'd1;

    always_comb begin
        n_at_start  = r_at_start;
        n_pend      = r_pend;
        n_accum     = r_accum;
        job.open_q  = r_at_start;
        job.op      = jse_pkg::OP_NONE;
        job.ch      = i_data_byte;
        job.code    = {{(jse_pkg::CP_W-8){1'b0}}, i_data_byte};
        job.close_q = 1'b0;
        if (i_kind) begin
            job.close_q = 1'b1;
            n_at_start  = 1'b1;
            n_pend      = 2'd0;
            n_accum     = '0;
            case (r_pend)
                2'd1:    job.code = {r_accum[jse_pkg::CP_W-7:0], 6'd0};
                2'd2:    job.code = {r_accum[jse_pkg::CP_W-13:0], 12'd0};
                2'd3:    job.code = {r_accum[jse_pkg::CP_W-19:0], 18'd0};
                default: job.code = r_accum;
            endcase
            if (r_pend != 2'd0) begin
                job.op = jse_pkg::OP_CODE;
            end
        end else begin
            n_at_start = 1'b0;
            if (r_pend != 2'd0) begin
                n_pend  = pend_dec;
                n_accum = acc_next;
                if (pend_dec == 2'd0) begin
                    job.op   = jse_pkg::OP_CODE;
                    job.code = acc_next;
                    n_accum  = '0;
                end
            end else begin
                job.op = jse_pkg::OP_ESC2;
                unique case (i_data_byte)
                    jse_pkg::CH_QUOTE: job.ch = jse_pkg::CH_QUOTE;
                    jse_pkg::CH_BSL:   job.ch = jse_pkg::CH_BSL;
                    jse_pkg::CH_SLASH: job.ch = jse_pkg::CH_SLASH;
                    8'h08:             job.ch = jse_pkg::CH_B;
                    8'h0C:             job.ch = jse_pkg::CH_F;
                    8'h0A:             job.ch = jse_pkg::CH_N;
                    8'h0D:             job.ch = jse_pkg::CH_R;
                    8'h09:             job.ch = jse_pkg::CH_T;
                    default: begin
                        if (i_data_byte < 8'h20) begin
                            job.op = jse_pkg::OP_CODE;
                        end else if (i_data_byte[7:4] == 4'hF) begin
                            job.op  = jse_pkg::OP_NONE;
                            n_accum = {{(jse_pkg::CP_W-3){1'b0}}, i_data_byte[2:0]};
                            n_pend  = 2'd3;
                        end else if (i_data_byte[7:5] == 3'b111) begin
                            job.op  = jse_pkg::OP_NONE;
                            n_accum = {{(jse_pkg::CP_W-4){1'b0}}, i_data_byte[3:0]};
                            n_pend  = 2'd2;
                        end else if (i_data_byte[7:6] == 2'b11) begin
                            job.op  = jse_pkg::OP_NONE;
                            n_accum = {{(jse_pkg::CP_W-5){1'b0}}, i_data_byte[4:0]};
                            n_pend  = 2'd1;
                        end else begin
                            job.op = jse_pkg::OP_RAW;
                        end
                    end
                endcase
            end
        end
    end

    assign o_job  = job;
    assign o_push = i_accept && (job.open_q || job.close_q || job.op != jse_pkg::OP_NONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_start <= 1'b1;
            r_pend     <= 2'd0;
            r_accum    <= '0;
        end else if (i_accept) begin
            r_at_start <= n_at_start;
            r_pend     <= n_pend;
            r_accum    <= n_accum;
        end
    end

endmodule

// File: rtl/jse_queue.sv
// ----------------------------------------------------------------------------
// jse_queue
// Small job queue between the classifier and the character sequencer.
// ----------------------------------------------------------------------------
module jse_queue #(
    parameter int DEPTH = jse_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  jse_pkg::t_job  i_job,
    output logic           o_full,
    output logic           o_valid,
    output jse_pkg::t_job  o_job,
    input  logic           i_pop
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    jse_pkg::t_job  r_mem [DEPTH];
    logic [PW-1:0]  r_wr, r_rd;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic           do_push, do_pop;

    assign o_full  = (r_cnt == FULL);
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (do_push) begin
                r_wr <= (r_wr == LAST) ? '0 : r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST) ? '0 : r_rd + PW'(1);
            end
        end
    end

endmodule

// File: rtl/jse_back.sv
// ----------------------------------------------------------------------------
// jse_back
// Expands one job into output characters, one per cycle while each result is
// taken, into the result register.
// ----------------------------------------------------------------------------
module jse_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  jse_pkg::t_job  i_job,
    output logic           o_pop,
    output logic           o_empty,
    output logic [7:0]     o_out_char,
    output logic           o_last_char,
    input  logic           i_pop
);

    localparam logic [1:0] PH_OPEN  = 2'd0;
    localparam logic [1:0] PH_BODY  = 2'd1;
    localparam logic [1:0] PH_CLOSE = 2'd2;

    logic [1:0]   r_phase, n_phase;
    logic [3:0]   r_idx, n_idx;
    logic         r_out_valid;
    logic [7:0]   r_out_char;
    logic         r_out_last;

    logic [3:0]   body_len;
    logic         pair;
    logic [19:0]  off;
    logic [15:0]  word;
    logic [3:0]   j;
    logic         cur_open, cur_body;
    logic         last_of_job;
    logic [7:0]   ch;
    logic [3:0]   nib;
    logic         load;

    assign off  = 20'(i_job.code - jse_pkg::CP_PLANE1);
    assign pair = (i_job.code > jse_pkg::CP_BMP_MAX);
    assign j    = (r_idx >= 4'd6) ? r_idx - 4'd6 : r_idx;

    always_comb begin
        case (i_job.op)
            jse_pkg::OP_RAW:  body_len = 4'd1;
            jse_pkg::OP_ESC2: body_len = 4'd2;
            jse_pkg::OP_CODE: body_len = pair ? 4'd12 : 4'd6;
            default:          body_len = 4'd0;
        endcase
        if (!pair) begin
            word = i_job.code[15:0];
        end else if (r_idx < 4'd6) begin
            word = {jse_pkg::SURR_HI, off[19:10]};
        end else begin
            word = {jse_pkg::SURR_LO, off[9:0]};
        end
        case (j)
            4'd2:    nib = word[15:12];
            4'd3:    nib = word[11:8];
            4'd4:    nib = word[7:4];
            default: nib = word[3:0];
        endcase
    end

    assign cur_open = (r_phase == PH_OPEN) && i_job.open_q;
    assign cur_body = !cur_open && (r_phase != PH_CLOSE) && (r_idx < body_len);

    always_comb begin
        ch          = jse_pkg::CH_QUOTE;
        last_of_job = 1'b1;
        n_phase     = PH_OPEN;
        n_idx       = '0;
        if (cur_open) begin
            last_of_job = (body_len == 4'd0) && !i_job.close_q;
            n_phase     = PH_BODY;
        end else if (cur_body) begin
            last_of_job = (r_idx + 4'd1 >= body_len) && !i_job.close_q;
            n_phase     = PH_BODY;
            n_idx       = r_idx + 4'd1;
            case (i_job.op)
                jse_pkg::OP_RAW:  ch = i_job.ch;
                jse_pkg::OP_ESC2: ch = (r_idx == 4'd0) ? jse_pkg::CH_BSL : i_job.ch;
                default: begin
                    if (j == 4'd0) begin
                        ch = jse_pkg::CH_BSL;
                    end else if (j == 4'd1) begin
                        ch = jse_pkg::CH_U;
                    end else begin
                        ch = jse_pkg::hex_char(nib);
                    end
                end
            endcase
        end
        if (last_of_job) begin
            n_phase = PH_OPEN;
            n_idx   = '0;
        end
    end

    assign load        = i_valid && (!r_out_valid || i_pop);
    assign o_pop       = load && last_of_job;
    assign o_empty     = !r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_last_char = r_out_last;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_char <= ch;
            r_out_last <= !cur_open && !cur_body;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_OPEN;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_phase     <= n_phase;
                r_idx       <= n_idx;
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// File: rtl/json_string_escaper.sv
// ----------------------------------------------------------------------------
// json_string_escaper
// Turns UTF-8 string bytes and an end-of-string item into a quoted, escaped
// JSON string literal, one character per transfer.
// ----------------------------------------------------------------------------
// Each input item is classified in the cycle it is taken. An item that sends
// characters is queued as one job; a lead byte or an inner continuation byte
// only updates the gathered code point and queues nothing, unless it carries
// the opening quote. The sequencer then sends one output character per cycle
// while it is popped. A plain byte gives one character, a two-character
// escape two, a \u escape six and a surrogate pair twelve, plus one each for
// the opening and closing quotes. Input is taken every cycle while the job
// queue (QUEUE_DEPTH jobs) has room; the character sequencer sets the rate.
module json_string_escaper #(
    parameter int QUEUE_DEPTH = jse_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_kind,
    input  logic [7:0]  i_data_byte,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_out_char,
    output logic        o_last_char
);

    jse_pkg::t_job  f_job, q_job;
    logic           f_push, q_valid, q_pop, q_full;

    assign full = q_full;

    jse_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (push && !q_full),
        .i_kind      (i_kind),
        .i_data_byte (i_data_byte),
        .o_push      (f_push),
        .o_job       (f_job)
    );

    jse_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_job   (f_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (q_job),
        .i_pop   (q_pop)
    );

    jse_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_job       (q_job),
        .o_pop       (q_pop),
        .o_empty     (empty),
        .o_out_char  (o_out_char),
        .o_last_char (o_last_char),
        .i_pop       (pop)
    );

endmodule

// File: rtl/jse_checker.sv
// ----------------------------------------------------------------------------
// jse_checker
// Port-level checks of the JSON string escaper, bound to the top level.
// ----------------------------------------------------------------------------
module jse_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        full,
    input  logic        empty,
    input  logic        pop,
    input  logic [7:0]  o_out_char,
    input  logic        o_last_char
);

    // closing marker only ever rides on a quote
    a_last_is_quote: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_last_char) |-> (o_out_char == jse_pkg::CH_QUOTE))
        else $error("last_char on a non-quote character");

    // control bytes never leave unescaped
    a_no_control: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_out_char >= 8'h20))
        else $error("raw control character in output");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out_char) && $stable(o_last_char)))
        else $error("result changed while stalled");

    // nothing waits and room is free right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("result present or queue full after reset");

endmodule

bind json_string_escaper jse_checker u_jse_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .full        (full),
    .empty       (empty),
    .pop         (pop),
    .o_out_char  (o_out_char),
    .o_last_char (o_last_char)
);

// File: dv/tb_json_string_escaper.sv
// ----------------------------------------------------------------------------
// tb_json_string_escaper
// Self-checking testbench of the JSON string escaper. After reset, a directed
// table covers every escape class, UTF-8 sequences, odd leads, truncation and
// the empty string; random strings of mixed content follow. A behavioral
// escaper predicts every output character, and each transfer is checked in
// order while both sides idle at random in several phases.
// ----------------------------------------------------------------------------
module tb_json_string_escaper;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam logic [7:0] CTL_BS  = 8'h08;
    localparam logic [7:0] CTL_TAB = 8'h09;
    localparam logic [7:0] CTL_LF  = 8'h0A;
    localparam logic [7:0] CTL_FF  = 8'h0C;
    localparam logic [7:0] CTL_CR  = 8'h0D;

    localparam int RAND_ITEMS = 120;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_lit_char;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
    } t_str_item;

    typedef struct {
        logic       kind;
        logic [7:0] data;
        bit         typed;
        string      lit;
    } t_dir_row;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       push        = 1'b0;
    logic       i_kind      = 1'b0;
    logic [7:0] i_data_byte = 8'h00;
    logic       pop         = 1'b0;
    logic       full;
    logic       empty;
    logic [7:0] o_out_char;
    logic       o_last_char;

    t_lit_char  lit_chars[$];
    t_str_item  str_items[$];
    t_dir_row   dir_rows[$];
    logic [7:0] esc_set[8];

    logic        esc_at_start = 1'b1;
    logic [1:0]  esc_pending  = 2'd0;
    logic [20:0] esc_code     = 21'd0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int err_cnt        = 0;

    json_string_escaper DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_kind      (i_kind),
        .i_data_byte (i_data_byte),
        .empty       (empty),
        .pop         (pop),
        .o_out_char  (o_out_char),
        .o_last_char (o_last_char)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void put_char(input logic [7:0] c, input logic l);
        t_lit_char lc;
        lc.ch   = c;
        lc.last = l;
        lit_chars.insert(lit_chars.size(), lc);
    endfunction

    function automatic void put_hex4(input logic [15:0] v);
        logic [7:0] nib;
        put_char(jse_pkg::CH_BSL, 1'b0);
        put_char(jse_pkg::CH_U, 1'b0);
        for (int s = 3; s >= 0; s--) begin
            nib = {4'd0, v[s*4 +: 4]};
            put_char((nib < 8'd10) ? 8'h30 + nib : 8'h41 + nib - 8'd10, 1'b0);
        end
    endfunction

    function automatic void put_code(input logic [20:0] cp);
        logic [20:0] off;
        if (cp <= jse_pkg::CP_BMP_MAX) begin
            put_hex4(cp[15:0]);
        end else begin
            off = cp - jse_pkg::CP_PLANE1;
            put_hex4(16'hD800 + {6'd0, off[19:10]});
            put_hex4(16'hDC00 + {6'd0, off[9:0]});
        end
    endfunction

    // one input item through the escaper, characters appended to lit_chars
    function automatic void escape_byte(input logic k, input logic [7:0] b);
        logic [20:0] v;
        if (esc_at_start) begin
            put_char(jse_pkg::CH_QUOTE, 1'b0);
            esc_at_start = 1'b0;
        end
        if (k == KIND_END) begin
            if (esc_pending != 2'd0) begin
                v = esc_code;
                for (int i = 0; i < int'(esc_pending); i++) begin
                    v = v << 6;
                end
                put_code(v);
            end
            put_char(jse_pkg::CH_QUOTE, 1'b1);
            esc_at_start = 1'b1;
            esc_pending  = 2'd0;
            esc_code     = 21'd0;
        end else if (esc_pending != 2'd0) begin
            esc_code    = {esc_code[14:0], b[5:0]};
            esc_pending = esc_pending - 2'd1;
            if (esc_pending == 2'd0) begin
                put_code(esc_code);
                esc_code = 21'd0;
            end
        end else begin
            case (b) inside
                jse_pkg::CH_QUOTE, jse_pkg::CH_BSL, jse_pkg::CH_SLASH: begin
                    put_char(jse_pkg::CH_BSL, 1'b0);
                    put_char(b, 1'b0);
                end
                CTL_BS: begin
                    put_char(jse_pkg::CH_BSL, 1'b0);
                    put_char(jse_pkg::CH_B, 1'b0);
                end
                CTL_FF: begin
                    put_char(jse_pkg::CH_BSL, 1'b0);
                    put_char(jse_pkg::CH_F, 1'b0);
                end
                CTL_LF: begin
                    put_char(jse_pkg::CH_BSL, 1'b0);
                    put_char(jse_pkg::CH_N, 1'b0);
                end
                CTL_CR: begin
                    put_char(jse_pkg::CH_BSL, 1'b0);
                    put_char(jse_pkg::CH_R, 1'b0);
                end
                CTL_TAB: begin
                    put_char(jse_pkg::CH_BSL, 1'b0);
                    put_char(jse_pkg::CH_T, 1'b0);
                end
                default: begin
                    if (b < 8'h20) begin
                        put_hex4({8'h00, b});
                    end else if (b[7:4] == 4'hF) begin
                        esc_code    = {18'd0, b[2:0]};
                        esc_pending = 2'd3;
                    end else if (b[7:5] == 3'b111) begin
                        esc_code    = {17'd0, b[3:0]};
                        esc_pending = 2'd2;
                    end else if (b[7:6] == 2'b11) begin
                        esc_code    = {16'd0, b[4:0]};
                        esc_pending = 2'd1;
                    end else begin
                        put_char(b, 1'b0);
                    end
                end
            endcase
        end
    endfunction

    function automatic void add_data(input logic [7:0] b);
        t_str_item it;
        it.kind = KIND_DATA;
        it.data = b;
        str_items.insert(str_items.size(), it);
    endfunction

    function automatic void add_seq(input logic [7:0] lead, input int n_cont);
        add_data(lead);
        for (int i = 0; i < n_cont; i++) begin
            add_data(8'h80 | 8'($urandom_range(63)));
        end
    endfunction

    // one random string, closed by an end item
    function automatic void add_string();
        int len;
        int pick;
        int need;
        t_str_item close_it;
        len = $urandom_range(10);
        for (int i = 0; i < len; i++) begin
            pick = $urandom_range(99);
            if (pick < 30) begin
                add_data(8'($urandom_range(8'h7E, 8'h20)));
            end else if (pick < 40) begin
                add_data(esc_set[$urandom_range(7)]);
            end else if (pick < 48) begin
                add_data(8'($urandom_range(8'h1F)));
            end else if (pick < 60) begin
                add_seq(8'hC0 | 8'($urandom_range(31)), 1);
            end else if (pick < 70) begin
                add_seq(8'hE0 | 8'($urandom_range(15)), 2);
            end else if (pick < 80) begin
                add_seq(8'hF0 | 8'($urandom_range(7)), 3);
            end else if (pick < 85) begin
                add_data(8'hF8 | 8'($urandom_range(7)));
                for (int j = 0; j < 3; j++) begin
                    add_data(8'($urandom_range(255)));
                end
            end else if (pick < 92) begin
                add_data(($urandom_range(9) == 0) ? 8'h7F : 8'($urandom_range(8'hBF, 8'h80)));
            end else begin
                add_data(8'($urandom_range(255)));
            end
        end
        if ($urandom_range(99) < 20) begin
            need = $urandom_range(3, 1);
            add_seq((need == 1) ? 8'hC0 | 8'($urandom_range(31)) :
                    (need == 2) ? 8'hE0 | 8'($urandom_range(15)) :
                                  8'hF0 | 8'($urandom_range(15)),
                    $urandom_range(need - 1));
        end
        close_it.kind = KIND_END;
        close_it.data = 8'($urandom_range(255));
        str_items.insert(str_items.size(), close_it);
    endfunction

    // called at a falling edge, returns at a falling edge after the transfer
    task automatic send_item(input logic k, input logic [7:0] b, input bit typed,
                             input string lit);
        int n0;
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push        <= 1'b1;
        i_kind      <= k;
        i_data_byte <= b;
        @(posedge i_clk);
        while (full) begin
            @(posedge i_clk);
        end
        n0 = lit_chars.size();
        escape_byte(k, b);
        if (typed) begin
            while (lit_chars.size() > n0) begin
                void'(lit_chars.pop_back());
            end
            for (int i = 0; i < lit.len(); i++) begin
                put_char(lit[i], (k == KIND_END) && (i == lit.len() - 1));
            end
        end
        @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        pop <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_lit_char exp_c;
        if (i_rst_n && pop && !empty) begin
            if (lit_chars.size() == 0) begin
                $display("%0t: unexpected transfer, expected none, actual char %h last %b",
                         $time, o_out_char, o_last_char);
                err_cnt++;
            end else begin
                exp_c = lit_chars.pop_front();
                if (o_out_char !== exp_c.ch) begin
                    $display("%0t: out_char mismatch, expected %h actual %h",
                             $time, exp_c.ch, o_out_char);
                    err_cnt++;
                end
                if (o_last_char !== exp_c.last) begin
                    $display("%0t: last_char mismatch, expected %b actual %b",
                             $time, exp_c.last, o_last_char);
                    err_cnt++;
                end
            end
        end
    end

    initial begin
        esc_set = '{jse_pkg::CH_QUOTE, jse_pkg::CH_BSL, jse_pkg::CH_SLASH,
                    CTL_BS, CTL_FF, CTL_LF, CTL_CR, CTL_TAB};
        dir_rows = '{
            '{KIND_DATA, 8'h41, 1'b1, "\"A"},
            '{KIND_DATA, 8'h00, 1'b1, "\\u0000"},
            '{KIND_DATA, 8'h1F, 1'b1, "\\u001F"},
            '{KIND_DATA, 8'h22, 1'b1, "\\\""},
            '{KIND_DATA, 8'h5C, 1'b1, "\\\\"},
            '{KIND_DATA, 8'h2F, 1'b1, "\\/"},
            '{KIND_DATA, 8'h08, 1'b1, "\\b"},
            '{KIND_DATA, 8'h0C, 1'b1, "\\f"},
            '{KIND_DATA, 8'h0A, 1'b1, "\\n"},
            '{KIND_DATA, 8'h0D, 1'b1, "\\r"},
            '{KIND_DATA, 8'h09, 1'b1, "\\t"},
            '{KIND_DATA, 8'h7F, 1'b0, ""},
            '{KIND_DATA, 8'h80, 1'b0, ""},
            '{KIND_DATA, 8'hC3, 1'b0, ""},
            '{KIND_DATA, 8'hA9, 1'b0, ""},
            '{KIND_DATA, 8'hF0, 1'b0, ""},
            '{KIND_DATA, 8'h9F, 1'b0, ""},
            '{KIND_DATA, 8'h98, 1'b0, ""},
            '{KIND_DATA, 8'h80, 1'b0, ""},
            '{KIND_DATA, 8'hFF, 1'b0, ""},
            '{KIND_DATA, 8'h22, 1'b0, ""},
            '{KIND_DATA, 8'h0A, 1'b0, ""},
            '{KIND_DATA, 8'h7F, 1'b0, ""},
            '{KIND_END,  8'hFF, 1'b1, "\""},
            '{KIND_END,  8'h00, 1'b1, "\"\""},
            '{KIND_DATA, 8'hE2, 1'b0, ""},
            '{KIND_END,  8'h00, 1'b0, ""}
        };

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            send_item(dir_rows[i].kind, dir_rows[i].data, dir_rows[i].typed,
                      dir_rows[i].lit);
        end

        while (str_items.size() < RAND_ITEMS) begin
            add_string();
        end
        foreach (str_items[i]) begin
            case (i * 4 / str_items.size())
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 73;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 73;
                end
                default: begin
                    send_idle_pct  = 33;
                    recv_stall_pct = 33;
                end
            endcase
            send_item(str_items[i].kind, str_items[i].data, 1'b0, "");
        end
        push <= 1'b0;

        while (lit_chars.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (40) @(posedge i_clk);

        if (err_cnt == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("%0t: timeout, %0d characters still expected", $time, lit_chars.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule
